FILE: rtl/gbn_pkg.sv
package gbn_pkg;

    localparam int SEQ_W     = 16;
    localparam int WIN_MAX   = 32;
    localparam int WIN_W     = 6;
    localparam int TIMEOUT_W = 16;
    localparam int RETRY_W   = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RETRIES   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_PACKETS = 2'd3;

    // Input command codes
    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_TICK  = 2'd1;
    localparam logic [1:0] CMD_ACK   = 2'd2;

    // Classified operations handed from the front end to the sequencer
    localparam logic [1:0] OP_START   = 2'd0;
    localparam logic [1:0] OP_TICK    = 2'd1;
    localparam logic [1:0] OP_ACK     = 2'd2;
    localparam logic [1:0] OP_ACK_BAD = 2'd3;

    // Result kinds
    localparam logic [1:0] KIND_SEND = 2'd0;
    localparam logic [1:0] KIND_DONE = 2'd1;
    localparam logic [1:0] KIND_FAIL = 2'd2;

    // Transfer phases
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_RUN  = 2'd1;
    localparam logic [1:0] PH_DONE = 2'd2;
    localparam logic [1:0] PH_FAIL = 2'd3;

    typedef struct packed {
        logic [1:0]       op;
        logic [SEQ_W-1:0] ack_num;
    } gbn_item_t;

    typedef struct packed {
        logic [1:0]       kind;
        logic [SEQ_W-1:0] seq_num;
        logic [SEQ_W-1:0] window_base;
        logic [15:0]      retransmissions;
        logic             last;
    } gbn_result_t;

endpackage

FILE: rtl/gbn_front.sv
module gbn_front import gbn_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [23:0]     s_tdata,   // ack_num [15:0], ack_ok [16], zero fill
    input  logic [1:0]      s_tuser,   // cmd [1:0]
    output logic            q_valid,
    input  logic            q_ready,
    output gbn_item_t       q_item
);

    gbn_item_t   mem_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        push, pop;
    gbn_item_t   item_in;

    assign s_tready = (count_reg != 2'd2);
    assign q_valid  = (count_reg != 2'd0);
    assign q_item   = mem_reg[rd_ptr_reg];

    // The unused command code causes nothing, so it never enters the queue.
    assign push = s_tvalid && s_tready && (s_tuser != 2'd3);
    assign pop  = q_valid && q_ready;

    always_comb begin
        item_in.ack_num = s_tdata[15:0];
        unique case (s_tuser)
            CMD_START: item_in.op = OP_START;
            CMD_TICK:  item_in.op = OP_TICK;
            CMD_ACK:   item_in.op = s_tdata[16] ? OP_ACK : OP_ACK_BAD;
            default:   item_in.op = OP_ACK_BAD;
        endcase
    end

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule

FILE: rtl/gbn_back.sv
module gbn_back import gbn_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  gbn_item_t            q_item,
    output logic                 res_valid,
    input  logic                 res_ready,
    output gbn_result_t          res
);

    localparam logic ST_PROC = 1'b0;
    localparam logic ST_FILL = 1'b1;

    // Configuration
    logic [WIN_W-1:0]     window_size_reg;
    logic [TIMEOUT_W-1:0] timeout_reg;
    logic [RETRY_W-1:0]   max_retries_reg;
    logic [SEQ_W-1:0]     total_reg;

    // Sender state
    logic                 state_reg, state_next;
    logic [SEQ_W-1:0]     base_reg, base_next;
    logic [SEQ_W-1:0]     next_reg, next_next;
    logic                 timer_on_reg, timer_on_next;
    logic [TIMEOUT_W-1:0] elapsed_reg, elapsed_next;
    logic [RETRY_W-1:0]   retry_reg, retry_next;
    logic [15:0]          retrans_reg, retrans_next;
    logic [1:0]           phase_reg, phase_next;

    // Output register
    logic                 out_valid_reg, out_valid_next;
    gbn_result_t          out_reg, out_next;

    logic                 out_free;
    logic [TIMEOUT_W-1:0] elapsed_inc;
    logic [RETRY_W-1:0]   retry_inc;
    logic [15:0]          retrans_inc;
    logic [SEQ_W:0]       ack_plus;
    logic [SEQ_W:0]       ack_clamp;
    logic [SEQ_W-1:0]     new_base;
    logic [SEQ_W-1:0]     new_next;
    logic [WIN_W-1:0]     win;
    logic [SEQ_W:0]       win_lim;
    logic [SEQ_W:0]       next_plus;
    logic                 can_send;
    logic                 more_after;

    assign out_free  = !out_valid_reg || res_ready;
    assign res_valid = out_valid_reg;
    assign res       = out_reg;
    assign q_ready   = (state_reg == ST_PROC) && out_free;

    always_comb begin
        elapsed_inc = (elapsed_reg != '1) ? elapsed_reg + 1'b1 : elapsed_reg;
        retry_inc   = (retry_reg != '1) ? retry_reg + 1'b1 : retry_reg;
        retrans_inc = (retrans_reg != '1) ? retrans_reg + 1'b1 : retrans_reg;

        // New base from a cumulative ack, held between the base and the total.
        ack_plus  = {1'b0, q_item.ack_num} + 1'b1;
        ack_clamp = (ack_plus > {1'b0, total_reg}) ? {1'b0, total_reg} : ack_plus;
        new_base  = (ack_clamp[SEQ_W-1:0] < base_reg) ? base_reg : ack_clamp[SEQ_W-1:0];
        new_next  = (next_reg < new_base) ? new_base : next_reg;

        win        = (window_size_reg > WIN_W'(WIN_MAX)) ? WIN_W'(WIN_MAX) : window_size_reg;
        win_lim    = {1'b0, base_reg} + {{(SEQ_W+1-WIN_W){1'b0}}, win};
        next_plus  = {1'b0, next_reg} + 1'b1;
        can_send   = ({1'b0, next_reg} < win_lim) && (next_reg < total_reg);
        more_after = (next_plus < win_lim) && (next_plus < {1'b0, total_reg});
    end

    always_comb begin
        state_next     = state_reg;
        base_next      = base_reg;
        next_next      = next_reg;
        timer_on_next  = timer_on_reg;
        elapsed_next   = elapsed_reg;
        retry_next     = retry_reg;
        retrans_next   = retrans_reg;
        phase_next     = phase_reg;
        out_valid_next = out_valid_reg && !res_ready;
        out_next       = out_reg;

        if (state_reg == ST_PROC) begin
            if (q_valid && out_free) begin
                unique case (q_item.op)
                    OP_START: begin
                        base_next     = '0;
                        next_next     = '0;
                        timer_on_next = 1'b0;
                        elapsed_next  = '0;
                        retry_next    = '0;
                        retrans_next  = '0;
                        phase_next    = PH_RUN;
                        state_next    = ST_FILL;
                    end
                    OP_TICK: begin
                        if (phase_reg == PH_RUN) begin
                            state_next = ST_FILL;
                            if (timer_on_reg) begin
                                elapsed_next = elapsed_inc;
                                if (elapsed_inc > timeout_reg) begin
                                    retry_next = retry_inc;
                                    if (retry_inc >= max_retries_reg) begin
                                        // Out of retries: report failure and stop here.
                                        phase_next                = PH_FAIL;
                                        state_next                = ST_PROC;
                                        out_valid_next            = 1'b1;
                                        out_next.kind             = KIND_FAIL;
                                        out_next.seq_num          = '0;
                                        out_next.window_base      = base_reg;
                                        out_next.retransmissions  = retrans_reg;
                                        out_next.last             = 1'b1;
                                    end else begin
                                        retrans_next  = retrans_inc;
                                        next_next     = base_reg;
                                        timer_on_next = 1'b0;
                                        elapsed_next  = '0;
                                    end
                                end
                            end
                        end
                    end
                    OP_ACK: begin
                        if (phase_reg == PH_RUN) begin
                            state_next = ST_FILL;
                            if (q_item.ack_num >= base_reg) begin
                                base_next     = new_base;
                                next_next     = new_next;
                                retry_next    = '0;
                                timer_on_next = (new_base != new_next);
                                elapsed_next  = '0;
                            end
                        end
                    end
                    OP_ACK_BAD: begin
                        if (phase_reg == PH_RUN) begin
                            state_next = ST_FILL;
                        end
                    end
                endcase
            end
        end else begin
            if (out_free) begin
                if (can_send) begin
                    out_valid_next           = 1'b1;
                    out_next.kind            = KIND_SEND;
                    out_next.seq_num         = next_reg;
                    out_next.window_base     = base_reg;
                    out_next.retransmissions = retrans_reg;
                    out_next.last            = !more_after;
                    next_next                = next_plus[SEQ_W-1:0];
                    if (base_reg == next_reg) begin
                        timer_on_next = 1'b1;
                        elapsed_next  = '0;
                    end
                    if (!more_after) begin
                        state_next = ST_PROC;
                    end
                end else begin
                    // Nothing to send this step; finish when every packet is acked.
                    if (base_reg >= total_reg) begin
                        phase_next               = PH_DONE;
                        timer_on_next            = 1'b0;
                        out_valid_next           = 1'b1;
                        out_next.kind            = KIND_DONE;
                        out_next.seq_num         = '0;
                        out_next.window_base     = base_reg;
                        out_next.retransmissions = retrans_reg;
                        out_next.last            = 1'b1;
                    end
                    state_next = ST_PROC;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_size_reg <= WIN_W'(4);
            timeout_reg     <= TIMEOUT_W'(100);
            max_retries_reg <= RETRY_W'(10);
            total_reg       <= SEQ_W'(1);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_WINDOW_SIZE:   window_size_reg <= cfg_data[WIN_W-1:0];
                CFG_TIMEOUT_TICKS: timeout_reg     <= cfg_data[TIMEOUT_W-1:0];
                CFG_MAX_RETRIES:   max_retries_reg <= cfg_data[RETRY_W-1:0];
                CFG_TOTAL_PACKETS: total_reg       <= cfg_data[SEQ_W-1:0];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_PROC;
            base_reg      <= '0;
            next_reg      <= '0;
            timer_on_reg  <= 1'b0;
            elapsed_reg   <= '0;
            retry_reg     <= '0;
            retrans_reg   <= '0;
            phase_reg     <= PH_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            base_reg      <= base_next;
            next_reg      <= next_next;
            timer_on_reg  <= timer_on_next;
            elapsed_reg   <= elapsed_next;
            retry_reg     <= retry_next;
            retrans_reg   <= retrans_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

endmodule

FILE: rtl/go_back_n_sender_window.sv
// Go-Back-N sender control with a two-entry command queue in front of the window sequencer.
// A failure result is registered straight from its command transfer; a send or done result
// is registered from the fill state that the command leads to.
// The sequencer takes no new command while it fills or while a result is stalled; a failing
// or ignored command skips the fill state. Reset (aresetn low, synchronous) empties the queue,
// returns the sender to idle and loads the register defaults; no clearing pass follows.
module go_back_n_sender_window import gbn_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [23:0]          s_tdata,   // ack_num [15:0], ack_ok [16], zero fill [23:17]
    input  logic [1:0]           s_tuser,   // cmd [1:0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [47:0]          m_tdata,   // seq_num, window_base, retransmissions
    output logic [1:0]           m_tuser,   // kind [1:0]
    output logic                 m_tlast
);

    logic        q_valid;
    logic        q_ready;
    gbn_item_t   q_item;
    gbn_result_t res;

    gbn_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    gbn_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_item    (q_item),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    assign m_tdata = {res.retransmissions, res.window_base, res.seq_num};
    assign m_tuser = res.kind;
    assign m_tlast = res.last;

endmodule

FILE: rtl/gbn_checker.sv
module gbn_checker import gbn_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    // A stalled result transfer keeps its contents.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("result changed while stalled");

    // Done and failed results always close the run of results for their command.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != KIND_SEND |-> m_tlast)
        else $error("done or failed result without last");

    // Done and failed results carry no sequence number.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != KIND_SEND |-> m_tdata[15:0] == 16'd0)
        else $error("done or failed result with a sequence number");

    // A send result for a packet below the window base would be stale.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_SEND |-> m_tdata[15:0] >= m_tdata[31:16])
        else $error("send below the window base");

    // Reset leaves no result pending.
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result pending after reset");

endmodule

bind go_back_n_sender_window gbn_checker u_gbn_checker (.*);
